// ----- src/ple_pkg.sv -----
// Shared types and constants for the positional list engine.
`default_nettype none

package ple_pkg;

  localparam int CAPACITY_DEF = 64;

  localparam int OP_W    = 3;
  localparam int POS_W   = 7;
  localparam int VAL_W   = 32;
  localparam int STAT_W  = 2;
  localparam int MATCH_W = 7;
  localparam int CNT_W   = 7;

  localparam int IN_DATA_W  = 40;  // position + value, padded to bytes
  localparam int IN_USER_W  = OP_W;
  localparam int OUT_DATA_W = 16;  // match_index + count, padded to bytes
  localparam int OUT_USER_W = STAT_W + 1;

  localparam logic [MATCH_W-1:0] MATCH_NONE = '1;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_BACK  = 3'd0,
    OP_PUSH_FRONT = 3'd1,
    OP_POP_BACK   = 3'd2,
    OP_POP_FRONT  = 3'd3,
    OP_INSERT     = 3'd4,
    OP_ERASE      = 3'd5,
    OP_FIND       = 3'd6,
    OP_CLEAR      = 3'd7
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2,
    STAT_RANGE = 2'd3
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PUT,
    S_FIND_RD,
    S_FIND_CMP,
    S_DONE
  } fsm_t;

endpackage

`default_nettype wire

// ----- src/ple_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
`default_nettype none

module ple_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- src/ple_alu.sv -----
// Shared step unit: index increment or decrement, bound compare and data equality.
`default_nettype none

module ple_alu #(
  parameter int LW = 7,
  parameter int DW = 32
) (
  input  wire logic [LW-1:0] idx,
  input  wire logic [LW-1:0] lim,
  input  wire logic          up,
  input  wire logic [DW-1:0] a,
  input  wire logic [DW-1:0] b,
  output logic      [LW-1:0] nxt,
  output logic               more,
  output logic               eq
);

  always_comb begin
    if (up) begin
      nxt  = idx + LW'(1);
      more = nxt < lim;
    end else begin
      nxt  = idx - LW'(1);
      more = nxt > lim;
    end
    eq = (a == b);
  end

endmodule

`default_nettype wire

// ----- src/positional_list_engine_top.sv -----
// Top level of the positional list engine: request decode, sequencer and list storage.
//
//   Channel  | Ports              | Contents (lowest bit first)
//   ---------+--------------------+---------------------------------------------
//   request  | in_t{valid,ready}  | tuser: op[2:0]; tdata: position[6:0],
//            |                    |   value[38:7], zero pad [39]
//   result   | out_t{valid,ready} | tuser: status[1:0], found[2]; tdata:
//            |                    |   match_index[6:0], count[13:7], pad [15:14]
//
// One request is in flight at a time. Push back, pop back, clear, a find on an
// empty list and every rejected request pass from idle straight to the done
// state, which hands the result to the output register and returns to idle.
// Pop front and erase add a read state and a write state for each entry that
// moves, push front and insert the same plus a state that puts the new value,
// and a find a read state and a compare state for each entry it compares. The
// split comes from the single read port of the list RAM, whose registered
// read must land before the shared step unit can use the data.
// Reset (synchronous, active low) empties the list; the RAM itself is not
// cleared, because only entries below the count are ever used.
// A finished result waits in the output register while the engine takes the
// next request; that request only stalls at its end if the result is still held.
`default_nettype none

module positional_list_engine_top #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  // Request channel.
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [ple_pkg::IN_DATA_W-1:0] in_tdata,   // position, value
  input  wire logic [ple_pkg::IN_USER_W-1:0] in_tuser,   // op
  // Result channel.
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [ple_pkg::OUT_DATA_W-1:0]     out_tdata,  // match_index, count
  output logic [ple_pkg::OUT_USER_W-1:0]     out_tuser   // status, found
);

  import ple_pkg::*;

  // Address width of the store and width of the count, which must hold CAPACITY.
  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int LW = $clog2(CAPACITY + 1);
  // Width used to compare an incoming position against the count.
  localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

  // Request fields.
  op_t              in_op;
  logic [POS_W-1:0] in_pos;
  logic [VAL_W-1:0] in_val;
  logic             accept;

  assign in_op  = op_t'(in_tuser);
  assign in_pos = in_tdata[POS_W-1:0];
  assign in_val = in_tdata[POS_W+VAL_W-1:POS_W];
  assign accept = in_tvalid && in_tready;

  // Sequencer and datapath registers.
  fsm_t               state_r, state_nxt;
  logic [LW-1:0]      length_r, length_nxt;
  logic [LW-1:0]      newlen_r, newlen_nxt;
  logic [LW-1:0]      idx_r, idx_nxt;
  logic [LW-1:0]      lim_r, lim_nxt;
  logic               up_r, up_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  stat_t              status_r, status_nxt;
  logic               found_r, found_nxt;
  logic [MATCH_W-1:0] match_r, match_nxt;

  logic                  out_tvalid_r, out_tvalid_nxt;
  logic [OUT_DATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [OUT_USER_W-1:0] out_tuser_r, out_tuser_nxt;

  // RAM and step unit connections.
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [VAL_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;
  logic [LW-1:0]    alu_nxt;
  logic             alu_more;
  logic             alu_eq;

  // Decode of an incoming request.
  fsm_t          go_state;
  stat_t         go_status;
  logic [LW-1:0] go_newlen;
  logic [LW-1:0] go_idx;
  logic [LW-1:0] go_lim;
  logic          go_up;
  logic          go_wr;

  logic [CW-1:0] pos_ext;
  logic [CW-1:0] len_ext;
  logic          full;
  logic          empty;
  logic          out_free;

  assign pos_ext  = CW'(in_pos);
  assign len_ext  = CW'(length_r);
  assign full     = (length_r == LW'(CAPACITY));
  assign empty    = (length_r == '0);
  assign out_free = !out_tvalid_r || out_tready;

  ple_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The one step unit serves both shifting directions and the find scan.
  ple_alu #(
    .LW (LW),
    .DW (VAL_W)
  ) u_alu (
    .idx  (idx_r),
    .lim  (lim_r),
    .up   (up_r),
    .a    (ram_rdata),
    .b    (val_r),
    .nxt  (alu_nxt),
    .more (alu_more),
    .eq   (alu_eq)
  );

  // Request decode. Opening a gap walks down from the count to the position,
  // closing a gap walks up from the position to one below the count.
  always_comb begin
    go_state  = S_DONE;
    go_status = STAT_OK;
    go_newlen = length_r;
    go_idx    = '0;
    go_lim    = length_r;
    go_up     = 1'b1;
    go_wr     = 1'b0;
    unique case (in_op)
      OP_PUSH_BACK: begin
        if (full) begin
          go_status = STAT_FULL;
        end else begin
          go_wr     = 1'b1;
          go_newlen = length_r + LW'(1);
        end
      end
      OP_PUSH_FRONT: begin
        if (full) begin
          go_status = STAT_FULL;
        end else begin
          go_idx    = length_r;
          go_lim    = '0;
          go_up     = 1'b0;
          go_newlen = length_r + LW'(1);
          go_state  = empty ? S_PUT : S_SHIFT_RD;
        end
      end
      OP_POP_BACK: begin
        if (empty) begin
          go_status = STAT_EMPTY;
        end else begin
          go_newlen = length_r - LW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (empty) begin
          go_status = STAT_EMPTY;
        end else begin
          go_idx    = '0;
          go_lim    = length_r - LW'(1);
          go_newlen = length_r - LW'(1);
          go_state  = (length_r > LW'(1)) ? S_SHIFT_RD : S_DONE;
        end
      end
      OP_INSERT: begin
        if (pos_ext > len_ext) begin
          go_status = STAT_RANGE;
        end else if (full) begin
          go_status = STAT_FULL;
        end else begin
          go_idx    = length_r;
          go_lim    = LW'(in_pos);
          go_up     = 1'b0;
          go_newlen = length_r + LW'(1);
          go_state  = (len_ext > pos_ext) ? S_SHIFT_RD : S_PUT;
        end
      end
      OP_ERASE: begin
        if (empty) begin
          go_status = STAT_EMPTY;
        end else if (pos_ext >= len_ext) begin
          go_status = STAT_RANGE;
        end else begin
          go_idx    = LW'(in_pos);
          go_lim    = length_r - LW'(1);
          go_newlen = length_r - LW'(1);
          go_state  = ((pos_ext + CW'(1)) < len_ext) ? S_SHIFT_RD : S_DONE;
        end
      end
      OP_FIND: begin
        go_idx   = '0;
        go_lim   = length_r;
        go_state = empty ? S_DONE : S_FIND_RD;
      end
      OP_CLEAR: begin
        go_newlen = '0;
      end
      default: begin
        go_state = S_DONE;
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = go_state;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (alu_more) begin
          state_nxt = S_SHIFT_RD;
        end else begin
          state_nxt = up_r ? S_DONE : S_PUT;
        end
      end
      S_PUT:     state_nxt = S_DONE;
      S_FIND_RD: state_nxt = S_FIND_CMP;
      S_FIND_CMP: begin
        if (alu_eq || !alu_more) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_FIND_RD;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Outputs of the sequencer: handshake and RAM controls.
  always_comb begin
    in_tready = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = idx_r[AW-1:0];
    ram_wdata = ram_rdata;
    ram_raddr = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        ram_we    = accept && go_wr;
        ram_waddr = length_r[AW-1:0];
        ram_wdata = in_val;
      end
      S_SHIFT_RD: ram_raddr = alu_nxt[AW-1:0];
      S_SHIFT_WR: ram_we = 1'b1;
      S_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = lim_r[AW-1:0];
        ram_wdata = val_r;
      end
      S_FIND_RD, S_FIND_CMP, S_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Datapath next values.
  always_comb begin
    length_nxt     = length_r;
    newlen_nxt     = newlen_r;
    idx_nxt        = idx_r;
    lim_nxt        = lim_r;
    up_nxt         = up_r;
    val_nxt        = val_r;
    status_nxt     = status_r;
    found_nxt      = found_r;
    match_nxt      = match_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    if (state_r == S_IDLE && accept) begin
      newlen_nxt = go_newlen;
      idx_nxt    = go_idx;
      lim_nxt    = go_lim;
      up_nxt     = go_up;
      val_nxt    = in_val;
      status_nxt = go_status;
      found_nxt  = 1'b0;
      match_nxt  = MATCH_NONE;
    end

    if (state_r == S_SHIFT_WR) begin
      idx_nxt = alu_nxt;
    end

    if (state_r == S_FIND_CMP) begin
      if (alu_eq) begin
        found_nxt = 1'b1;
        match_nxt = MATCH_W'(idx_r);
      end else begin
        idx_nxt = alu_nxt;
      end
    end

    // The count only changes when the result is handed to the output register.
    if (state_r == S_DONE && out_free) begin
      length_nxt     = newlen_r;
      out_tvalid_nxt = 1'b1;
      out_tdata_nxt  = OUT_DATA_W'({CNT_W'(newlen_r), match_r});
      out_tuser_nxt  = {found_r, status_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      length_r     <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      length_r     <= length_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    newlen_r    <= newlen_nxt;
    idx_r       <= idx_nxt;
    lim_r       <= lim_nxt;
    up_r        <= up_nxt;
    val_r       <= val_nxt;
    status_r    <= status_nxt;
    found_r     <= found_nxt;
    match_r     <= match_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

endmodule

`default_nettype wire

// ----- src/ple_checker.sv -----
// Port-level checker for the positional list engine, bound to the top level.
`default_nettype none

module ple_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic [2:0]  out_tuser
);

  // A held result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // The engine is busy right after it takes a request.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while a previous one was in flight");

  // A match only comes with an ok status.
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[2] |-> out_tuser[1:0] == 2'd0)
    else $error("match reported with an error status");

  // Without a match the index reads as minus one.
  a_no_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[2] |-> out_tdata[6:0] == 7'h7F)
    else $error("match index set without a match");

  // Reset leaves the engine idle with no result pending.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready)
    else $error("engine not idle after reset");

endmodule

bind positional_list_engine_top ple_checker u_ple_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire

// ----- bench/ple_checker.sv -----
// Checker for the positional list engine: predicts every result and compares it.
`timescale 1ns / 100ps

module ple_list_checker #(
  parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [ple_pkg::IN_DATA_W-1:0]   in_tdata,   // position, value
  input  wire logic [ple_pkg::IN_USER_W-1:0]   in_tuser,   // op
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [ple_pkg::OUT_DATA_W-1:0]  out_tdata,  // match_index, count
  input  wire logic [ple_pkg::OUT_USER_W-1:0]  out_tuser,  // status, found
  output int                                   errors,
  output int                                   pending,
  output int                                   checked,
  output int                                   full_rejects,
  output int                                   find_hits
);
  import ple_pkg::*;

  typedef struct packed {
    stat_t              status;
    logic               found;
    logic [MATCH_W-1:0] match_index;
    logic [CNT_W-1:0]   count;
  } list_result_t;

  // Shadow copy of the list contents and its length.
  logic [VAL_W-1:0] shadow_list [CAPACITY];
  int               shadow_len;
  list_result_t     expected_results [$];

  task automatic report_mismatch(input string msg);
    $display("[%0t] list check: %s", $realtime, msg);
    errors++;
  endtask

  // Applies one request to the shadow list and returns the result it should produce.
  task automatic predict_list_op(input op_t op, input logic [POS_W-1:0] pos,
                                 input logic [VAL_W-1:0] val, output list_result_t res);
    int i;
    res.status      = STAT_OK;
    res.found       = 1'b0;
    res.match_index = MATCH_NONE;
    case (op)
      OP_PUSH_BACK: begin
        if (shadow_len >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          shadow_list[shadow_len] = val;
          shadow_len++;
        end
      end
      OP_PUSH_FRONT, OP_INSERT: begin
        if (op == OP_INSERT && int'(pos) > shadow_len) begin
          res.status = STAT_RANGE;
        end else if (shadow_len >= CAPACITY) begin
          res.status = STAT_FULL;
        end else begin
          if (op == OP_PUSH_FRONT) pos = '0;
          for (i = shadow_len; i > int'(pos); i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = val;
          shadow_len++;
        end
      end
      OP_POP_BACK: begin
        if (shadow_len == 0) res.status = STAT_EMPTY;
        else shadow_len--;
      end
      OP_POP_FRONT, OP_ERASE: begin
        if (op == OP_POP_FRONT) pos = '0;
        if (shadow_len == 0) begin
          res.status = STAT_EMPTY;
        end else if (int'(pos) >= shadow_len) begin
          res.status = STAT_RANGE;
        end else begin
          for (i = int'(pos); i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      OP_FIND: begin
        for (i = 0; i < shadow_len; i++) begin
          if (shadow_list[i] == val) begin
            res.found       = 1'b1;
            res.match_index = MATCH_W'(i);
            break;
          end
        end
      end
      default: shadow_len = 0;
    endcase
    res.count = CNT_W'(shadow_len);
  endtask

  always @(posedge clk) begin : watch
    list_result_t got, want, fresh;
    if (!rst_n) begin
      shadow_len = 0;
      expected_results.delete();
    end else begin
      // Results are handled before requests: no result can belong to a request
      // accepted at the same edge.
      if (out_tvalid && out_tready) begin
        got.status      = stat_t'(out_tuser[STAT_W-1:0]);
        got.found       = out_tuser[STAT_W];
        got.match_index = out_tdata[MATCH_W-1:0];
        got.count       = out_tdata[MATCH_W +: CNT_W];
        checked++;
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result %0d arrived with no request waiting", checked));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch($sformatf("result %0d status %0d, expected %0d",
                                      checked, got.status, want.status));
          if (got.found !== want.found)
            report_mismatch($sformatf("result %0d found %0b, expected %0b",
                                      checked, got.found, want.found));
          if (got.match_index !== want.match_index)
            report_mismatch($sformatf("result %0d match_index %0h, expected %0h",
                                      checked, got.match_index, want.match_index));
          if (got.count !== want.count)
            report_mismatch($sformatf("result %0d count %0d, expected %0d",
                                      checked, got.count, want.count));
          if (want.status == STAT_FULL) full_rejects++;
          if (want.found) find_hits++;
        end
      end
      if (in_tvalid && in_tready) begin
        predict_list_op(op_t'(in_tuser), in_tdata[POS_W-1:0],
                        in_tdata[POS_W +: VAL_W], fresh);
        expected_results.push_back(fresh);
      end
    end
    pending = expected_results.size();
  end

endmodule

// ----- bench/tb_top.sv -----
// Top of the positional list engine testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module tb_top;
  import ple_pkg::*;

  localparam int CAPACITY       = CAPACITY_DEF;
  // The slowest request moves about CAPACITY entries, a read and a write for each.
  // Even with every result stalled this limit leaves several times the margin.
  localparam int CYCLE_LIMIT    = 1_000_000;
  localparam int DRAIN_CYCLES   = 4 * CAPACITY + 40;
  localparam int HOLDOFF_CYCLES = 400;
  localparam int PHASE_ITEMS    = 285;

  // Idle mixes per phase, in percent: sender idle, receiver stalling.
  localparam int TX_IDLE  [4] = '{0, 84, 0, 17};
  localparam int RX_STALL [4] = '{0, 0, 84, 17};

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;  // position[6:0], value[38:7], pad[39]
  logic [IN_USER_W-1:0]  in_tuser   = '0;  // op[2:0]
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;        // match_index[6:0], count[13:7], pad[15:14]
  logic [OUT_USER_W-1:0] out_tuser;        // status[1:0], found[2]

  int errors, pending, checked, full_rejects, find_hits;

  // Knobs shared by the stimulus and the result sink; the stimulus process is
  // the only writer of each of them.
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int holdoff_req   = 0;
  int requests_sent = 0;

  // Cycles seen by the watchdog.
  int cycle_count   = 0;

  // A small pool of values, so that finds hit entries often. The extremes of
  // the signed range and the all-ones pattern are in it.
  logic [VAL_W-1:0] value_pool [8] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                       32'hFFFF_FFFF, 32'h0000_0001, 32'h5A5A_5A5A,
                                       32'h0000_0040, 32'hA5A5_0001};

  positional_list_engine_top #(.CAPACITY(CAPACITY)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  ple_list_checker #(.CAPACITY(CAPACITY)) u_list_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .errors       (errors),
    .pending      (pending),
    .checked      (checked),
    .full_rejects (full_rejects),
    .find_hits    (find_hits)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one request transaction. It is called at a falling edge and returns
  // at the falling edge after the transaction was accepted, so that every input
  // changes only at falling edges. Random idle cycles come first; when there
  // are none, tvalid stays high from one transaction into the next.
  task automatic offer_request(input op_t op, input logic [POS_W-1:0] pos,
                               input logic [VAL_W-1:0] val);
    while (tx_idle_pct > 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {1'b0, val, pos};
    do @(posedge clk); while (!in_tready);
    requests_sent++;
    @(negedge clk);
  endtask

  // Draws one random request. add_pct sets how much of the non-find traffic
  // grows the list, so that a phase can fill the store and then drain it.
  task automatic random_request(input int add_pct, output op_t op,
                                output logic [POS_W-1:0] pos, output logic [VAL_W-1:0] val);
    int r;
    r = $urandom_range(99);
    if (r == 0) begin
      op = OP_CLEAR;
    end else if (r < 15) begin
      op = OP_FIND;
    end else if (r < 15 + add_pct * 85 / 100) begin
      case ($urandom_range(2))
        0:       op = OP_PUSH_BACK;
        1:       op = OP_PUSH_FRONT;
        default: op = OP_INSERT;
      endcase
    end else begin
      case ($urandom_range(2))
        0:       op = OP_POP_BACK;
        1:       op = OP_POP_FRONT;
        default: op = OP_ERASE;
      endcase
    end
    // Positions lean toward small indexes, where they are often valid even on a
    // short list; the top two indexes get extra weight.
    r = $urandom_range(99);
    if (r < 45)      pos = POS_W'($urandom_range(8));
    else if (r < 55) pos = $urandom_range(1) ? POS_W'(64) : POS_W'(63);
    else             pos = POS_W'($urandom_range(64));
    // Finds mostly search for pool values; stored values are half pool, half random.
    if ($urandom_range(99) < ((op == OP_FIND) ? 80 : 50))
      val = value_pool[$urandom_range(7)];
    else
      val = $urandom;
  endtask

  // Result sink. It stalls at random, and on request it holds off for a long
  // stretch so that the engine fills its output register and stops accepting.
  initial begin : result_sink
    int hold_left;
    int seen_req;
    hold_left = 0;
    seen_req  = 0;
    forever begin
      @(negedge clk);
      if (holdoff_req != seen_req) begin
        seen_req  = holdoff_req;
        hold_left = HOLDOFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // Watchdog: a correct run ends well inside this many cycles.
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             cycle_count, pending);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    op_t              op;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
    int               ph;
    int               n;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part. Every request on an empty list must be rejected or be a
    // harmless find, then the list is built with the extreme values and taken
    // apart again through each operation.
    offer_request(OP_POP_BACK,   7'd0,  32'h0);
    offer_request(OP_POP_FRONT,  7'd0,  32'h0);
    offer_request(OP_ERASE,      7'd0,  32'h0);
    offer_request(OP_FIND,       7'd0,  32'h0);
    offer_request(OP_INSERT,     7'd1,  32'h1);          // position past the end
    offer_request(OP_INSERT,     7'd0,  32'h8000_0000);
    offer_request(OP_PUSH_BACK,  7'd0,  32'h7FFF_FFFF);
    offer_request(OP_PUSH_FRONT, 7'd0,  32'h0000_0000);
    offer_request(OP_PUSH_BACK,  7'd0,  32'hFFFF_FFFF);
    offer_request(OP_INSERT,     7'd4,  32'h5555_5555);  // exactly at the end
    offer_request(OP_INSERT,     7'd64, 32'h1234_5678);  // far past the end
    offer_request(OP_INSERT,     7'd63, 32'h1234_5678);
    offer_request(OP_FIND,       7'd0,  32'h7FFF_FFFF);
    offer_request(OP_FIND,       7'd0,  32'hFFFF_FFFF);
    offer_request(OP_FIND,       7'd0,  32'h1234_5678);  // no match
    offer_request(OP_ERASE,      7'd5,  32'h0);          // at the end, out of range
    offer_request(OP_ERASE,      7'd2,  32'h0);
    offer_request(OP_POP_FRONT,  7'd0,  32'h0);
    offer_request(OP_POP_BACK,   7'd0,  32'h0);
    offer_request(OP_CLEAR,      7'd0,  32'h0);
    offer_request(OP_PUSH_BACK,  7'd0,  32'hAAAA_AAAA);
    offer_request(OP_ERASE,      7'd0,  32'h0);

    // Fill the store to capacity, then try every way of growing it. An insert
    // at the end of a full list passes the position check and hits the full one.
    for (n = 0; n < CAPACITY + 1; n++)
      offer_request(OP_PUSH_BACK, 7'd0, value_pool[$urandom_range(7)]);
    offer_request(OP_PUSH_FRONT, 7'd0,  32'h0);
    offer_request(OP_INSERT,     7'd64, 32'h0);
    offer_request(OP_INSERT,     7'd10, 32'h0);
    offer_request(OP_ERASE,      7'd64, 32'h0);
    offer_request(OP_ERASE,      7'd63, 32'h0);

    // Random phases. The first half of each phase mostly grows the list and
    // the second half mostly shrinks it, so that both full and empty are hit
    // under every idle mix. The first phase also starts the long hold-off.
    for (ph = 0; ph < 4; ph++) begin
      tx_idle_pct  = TX_IDLE[ph];
      rx_stall_pct = RX_STALL[ph];
      if (ph == 0) holdoff_req++;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        random_request((n < PHASE_ITEMS / 2) ? 80 : 25, op, pos, val);
        offer_request(op, pos, val);
      end
    end
    in_tvalid <= 1'b0;

    // Wait for every outstanding result, then give the engine time to show any
    // transaction it should not produce.
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests across four idle and stall mixes and one long hold-off.",
             requests_sent);
    $display("Checked %0d results, %0d rejected as full and %0d finds with a match.",
             checked, full_rejects, find_hits);
    if (errors == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
